@@ src/ngll_pkg.sv @@
package ngll_pkg;

  // Parse phase of the current buffer.
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_FIELDS = 2'd1,
    PH_DONE   = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_HEADER  = 2'd1,
    ST_FEW_FIELDS = 2'd2
  } status_t;

  // Field widths of one result.
  localparam int INT_W   = 20;
  localparam int FRAC_W  = 27;
  localparam int CHARS_W = 4;
  localparam int TDATA_W = 160;

  // Digit limits and field length limit.
  localparam int INT_DIGITS      = 6;
  localparam int FRAC_DIGITS     = 8;
  localparam int MAX_FIELD_CHARS = 15;
  localparam int FLEN_W          = $clog2(MAX_FIELD_CHARS + 1);

  // Header and separator characters.
  localparam int         HDR_LEN   = 6;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Comma count at which the sentence is complete, and the fix field number.
  localparam logic [2:0] COMMAS_DONE = 3'd7;
  localparam logic [2:0] FIX_FIELD   = 3'd6;
  localparam logic [2:0] LAST_SAVED  = 3'd5;

  localparam logic [CHARS_W-1:0] CHARS_MAX = '1;

  function automatic logic [63:0] pow_ten(input int n);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < n; i++) begin
      v = v * 64'd10;
    end
    return v;
  endfunction

  localparam logic [INT_W-1:0]  INT_MAX  = INT_W'(pow_ten(INT_DIGITS) - 64'd1);
  localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(pow_ten(FRAC_DIGITS) - 64'd1);

  // Expected header character at a match position ("$GNGLL").
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h4C;
      3'd5:    c = 8'h4C;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

@@ src/nmea_gll_sentence_parser_unit.sv @@
// Channel  Direction  Transaction contents
// in_      slave      tdata: char_in (one buffer byte); tlast: last_byte
// out_     master     tuser: status; tdata: lat, lon, utc fields and fix_valid
//
// One byte is taken per cycle unless a stalled result holds it; a byte passes an
// input register, then the parse logic, and its result lands in the output register.
// The parse state (header match, comma count, field accumulators) updates once per byte.
// rst_n is synchronous and active low; all parse state also clears after a tlast byte.
// A stalled result holds the pipeline; the input register still fills while
// the output register waits, so in_tready falls only when both are occupied.
module nmea_gll_sentence_parser_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] char_in
  input  logic                        in_tlast,   // last_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [19:0] lat_int, [46:20] lat_frac, [50:47] lat_frac_chars,
  // [70:51] lon_int, [97:71] lon_frac, [101:98] lon_frac_chars,
  // [121:102] utc_int, [148:122] utc_frac, [152:149] utc_frac_chars,
  // [153] fix_valid, [159:154] zero
  output logic [ngll_pkg::TDATA_W-1:0] out_tdata,
  output logic [1:0]                  out_tuser   // [1:0] status
);
  import ngll_pkg::*;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       advance;

  // Parse state.
  phase_t              phase_r, phase_nxt;
  logic [2:0]          hdr_pos_r, hdr_pos_nxt;
  logic [2:0]          comma_cnt_r, comma_cnt_nxt;
  logic [INT_W-1:0]    int_acc_r, int_acc_nxt;
  logic [FRAC_W-1:0]   frac_acc_r, frac_acc_nxt;
  logic [CHARS_W-1:0]  frac_chars_r, frac_chars_nxt;
  logic                pt_seen_r, pt_seen_nxt;
  logic                stop_r, stop_nxt;
  logic [FLEN_W-1:0]   flen_r, flen_nxt;
  logic                fix_r, fix_nxt;

  // Saved latitude, longitude and UTC fields.
  logic [INT_W-1:0]    sav_int_r   [3];
  logic [FRAC_W-1:0]   sav_frac_r  [3];
  logic [CHARS_W-1:0]  sav_chars_r [3];
  logic                sav_we;
  logic [1:0]          sav_idx;

  // Output register.
  logic                out_valid_r;
  logic [TDATA_W-1:0]  out_data_r;
  status_t             out_status_r;
  logic                emit;
  status_t             emit_status;
  logic [TDATA_W-1:0]  emit_data;

  // Digit arithmetic.
  logic                is_digit;
  logic [3:0]          digit;
  logic [INT_W+3:0]    int_mac;
  logic [FRAC_W+3:0]   frac_mac;
  logic [INT_W-1:0]    int_sat;
  logic [FRAC_W-1:0]   frac_sat;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  assign is_digit = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
  assign digit    = 4'(s1_char_r - CH_ZERO);
  assign int_mac  = (INT_W+4)'(int_acc_r) * (INT_W+4)'(10) + (INT_W+4)'(digit);
  assign frac_mac = (FRAC_W+4)'(frac_acc_r) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);
  assign int_sat  = (int_mac > (INT_W+4)'(INT_MAX)) ? INT_MAX : int_mac[INT_W-1:0];
  assign frac_sat = (frac_mac > (FRAC_W+4)'(FRAC_MAX)) ? FRAC_MAX : frac_mac[FRAC_W-1:0];

  // Slot of the field that a comma closes: fields 1, 3 and 5 are kept.
  assign sav_idx = comma_cnt_r[2:1];

  // Next parse state and result for the byte in the input register.
  always_comb begin
    phase_nxt      = phase_r;
    hdr_pos_nxt    = hdr_pos_r;
    comma_cnt_nxt  = comma_cnt_r;
    int_acc_nxt    = int_acc_r;
    frac_acc_nxt   = frac_acc_r;
    frac_chars_nxt = frac_chars_r;
    pt_seen_nxt    = pt_seen_r;
    stop_nxt       = stop_r;
    flen_nxt       = flen_r;
    fix_nxt        = fix_r;
    sav_we         = 1'b0;
    emit           = 1'b0;
    emit_status    = ST_OK;
    emit_data      = '0;

    unique case (phase_r)
      PH_SEARCH: begin
        if (s1_char_r == CH_NUL) begin
          phase_nxt = PH_STOP;
        end else begin
          if (s1_char_r == hdr_char(hdr_pos_r)) begin
            hdr_pos_nxt = hdr_pos_r + 3'd1;
          end else if (s1_char_r == CH_DOLLAR) begin
            hdr_pos_nxt = 3'd1;
          end else begin
            hdr_pos_nxt = 3'd0;
          end
          if (hdr_pos_nxt == 3'(HDR_LEN)) begin
            phase_nxt      = PH_FIELDS;
            comma_cnt_nxt  = 3'd0;
            int_acc_nxt    = '0;
            frac_acc_nxt   = '0;
            frac_chars_nxt = '0;
            pt_seen_nxt    = 1'b0;
            stop_nxt       = 1'b0;
            flen_nxt       = '0;
          end
        end
      end
      PH_FIELDS: begin
        if (s1_char_r == CH_NUL) begin
          phase_nxt = PH_STOP;
        end else if (s1_char_r == CH_COMMA) begin
          // Close the current field; keep latitude, longitude and UTC.
          sav_we         = comma_cnt_r[0] && (comma_cnt_r <= LAST_SAVED);
          comma_cnt_nxt  = comma_cnt_r + 3'd1;
          int_acc_nxt    = '0;
          frac_acc_nxt   = '0;
          frac_chars_nxt = '0;
          pt_seen_nxt    = 1'b0;
          stop_nxt       = 1'b0;
          flen_nxt       = '0;
          if (comma_cnt_nxt == COMMAS_DONE) begin
            emit        = 1'b1;
            emit_status = ST_OK;
            emit_data   = {6'd0, fix_r,
                           sav_chars_r[2], sav_frac_r[2], sav_int_r[2],
                           sav_chars_r[1], sav_frac_r[1], sav_int_r[1],
                           sav_chars_r[0], sav_frac_r[0], sav_int_r[0]};
            phase_nxt   = PH_DONE;
          end
        end else if ((comma_cnt_r != 3'd0) && (flen_r < FLEN_W'(MAX_FIELD_CHARS))) begin
          flen_nxt = flen_r + 1'b1;
          if ((comma_cnt_r == FIX_FIELD) && (flen_r == '0)) begin
            fix_nxt = (s1_char_r == CH_A);
          end
          // Integer part up to the point, fraction after it.
          if (!pt_seen_r) begin
            if (s1_char_r == CH_POINT) begin
              pt_seen_nxt = 1'b1;
              stop_nxt    = 1'b0;
            end else if (!stop_r) begin
              if (is_digit) begin
                int_acc_nxt = int_sat;
              end else begin
                stop_nxt = 1'b1;
              end
            end
          end else begin
            if (frac_chars_r != CHARS_MAX) begin
              frac_chars_nxt = frac_chars_r + 1'b1;
            end
            if (!stop_r) begin
              if (is_digit) begin
                frac_acc_nxt = frac_sat;
              end else begin
                stop_nxt = 1'b1;
              end
            end
          end
        end
      end
      PH_DONE, PH_STOP: begin
      end
      default: begin
      end
    endcase

    // End of buffer: report a failure if no result went out, then start over.
    if (s1_last_r) begin
      if (phase_nxt != PH_DONE) begin
        emit        = 1'b1;
        emit_status = (hdr_pos_nxt == 3'(HDR_LEN)) ? ST_FEW_FIELDS : ST_NO_HEADER;
        emit_data   = '0;
      end
      phase_nxt      = PH_SEARCH;
      hdr_pos_nxt    = 3'd0;
      comma_cnt_nxt  = 3'd0;
      int_acc_nxt    = '0;
      frac_acc_nxt   = '0;
      frac_chars_nxt = '0;
      pt_seen_nxt    = 1'b0;
      stop_nxt       = 1'b0;
      flen_nxt       = '0;
      fix_nxt        = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEARCH;
      hdr_pos_r    <= 3'd0;
      comma_cnt_r  <= 3'd0;
      int_acc_r    <= '0;
      frac_acc_r   <= '0;
      frac_chars_r <= '0;
      pt_seen_r    <= 1'b0;
      stop_r       <= 1'b0;
      flen_r       <= '0;
      fix_r        <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      hdr_pos_r    <= hdr_pos_nxt;
      comma_cnt_r  <= comma_cnt_nxt;
      int_acc_r    <= int_acc_nxt;
      frac_acc_r   <= frac_acc_nxt;
      frac_chars_r <= frac_chars_nxt;
      pt_seen_r    <= pt_seen_nxt;
      stop_r       <= stop_nxt;
      flen_r       <= flen_nxt;
      fix_r        <= fix_nxt;
    end
  end

  // Saved field values, written when a kept field is closed.
  always_ff @(posedge clk) begin
    if (advance && sav_we) begin
      sav_int_r[sav_idx]   <= int_acc_r;
      sav_frac_r[sav_idx]  <= frac_acc_r;
      sav_chars_r[sav_idx] <= frac_chars_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && emit) begin
      out_data_r   <= emit_data;
      out_status_r <= emit_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
